>>> rtl/chip8_instruction_execute_defines.svh
// Assertion macros shared by the chip8_instruction_execute RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define C8IE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define C8IE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/c8ie_pkg.sv
// Package for the CHIP-8 execute unit: widths, opcodes, constants, structs.
// No dependencies; used by c8ie_if, c8ie_exec, the top level and the bench.
package c8ie_pkg;

    localparam int OP_W      = 5;
    localparam int NIB_W     = 4;
    localparam int REG_W     = 8;
    localparam int ADDR_W    = 12;
    localparam int KEY_W     = 16;
    localparam int NUM_REGS  = 16;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-3:0] CFG_IDX_START = '0;

    localparam logic [ADDR_W-1:0] START_RESET = 12'h200;
    localparam logic [ADDR_W-1:0] PC_STEP     = 12'd2;
    localparam logic [NIB_W-1:0]  FLAG_REG    = 4'hF;
    localparam logic [REG_W-1:0]  KEY_DOWN    = 8'h9E;
    localparam logic [REG_W-1:0]  KEY_UP      = 8'hA1;

    typedef enum logic [OP_W-1:0] {
        OP_RET   = 5'd0,
        OP_JMP   = 5'd1,
        OP_CALL  = 5'd2,
        OP_SKEQI = 5'd3,
        OP_SKNEI = 5'd4,
        OP_SKEQR = 5'd5,
        OP_SKNER = 5'd6,
        OP_SETNN = 5'd7,
        OP_ADDNN = 5'd8,
        OP_SETI  = 5'd9,
        OP_MOV   = 5'd10,
        OP_OR    = 5'd11,
        OP_AND   = 5'd12,
        OP_XOR   = 5'd13,
        OP_ADDC  = 5'd14,
        OP_SUBN  = 5'd15,
        OP_SHR   = 5'd16,
        OP_SHL   = 5'd17,
        OP_JMPV0 = 5'd18,
        OP_RAND  = 5'd19,
        OP_KEY   = 5'd20
    } t_op;

    // One decoded instruction
    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [NIB_W-1:0] reg_x;
        logic [NIB_W-1:0] reg_y;
        logic [NIB_W-1:0] nibble_n;
        logic [REG_W-1:0] random_byte;
        logic [KEY_W-1:0] key_states;
    } t_item;

    // Execute outcome, also the result item payload
    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic [ADDR_W-1:0] index_value;
        logic              reg_written;
        logic [NIB_W-1:0]  written_reg;
        logic [REG_W-1:0]  written_value;
        logic              flag_written;
        logic              flag_value;
        logic              stack_fault;
    } t_result;

    // Stack control from execute to the state update
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [ADDR_W-1:0] push_data;
    } t_stk_ctl;

endpackage

>>> rtl/c8ie_if.sv
// Valid/ready channel interfaces for instruction items and result items.
// Depends on c8ie_pkg for field widths.
interface c8ie_item_if;
    logic                           valid;
    logic                           ready;
    logic [c8ie_pkg::OP_W-1:0]      operation;
    logic [c8ie_pkg::NIB_W-1:0]     reg_x;
    logic [c8ie_pkg::NIB_W-1:0]     reg_y;
    logic [c8ie_pkg::NIB_W-1:0]     nibble_n;
    logic [c8ie_pkg::REG_W-1:0]     random_byte;
    logic [c8ie_pkg::KEY_W-1:0]     key_states;

    modport source (output valid, operation, reg_x, reg_y, nibble_n, random_byte,
                    key_states, input ready);
    modport sink (input valid, operation, reg_x, reg_y, nibble_n, random_byte,
                  key_states, output ready);
endinterface

interface c8ie_result_if;
    logic                           valid;
    logic                           ready;
    logic [c8ie_pkg::ADDR_W-1:0]    next_pc;
    logic [c8ie_pkg::ADDR_W-1:0]    index_value;
    logic                           reg_written;
    logic [c8ie_pkg::NIB_W-1:0]     written_reg;
    logic [c8ie_pkg::REG_W-1:0]     written_value;
    logic                           flag_written;
    logic                           flag_value;
    logic                           stack_fault;

    modport source (output valid, next_pc, index_value, reg_written, written_reg,
                    written_value, flag_written, flag_value, stack_fault, input ready);
    modport sink (input valid, next_pc, index_value, reg_written, written_reg,
                  written_value, flag_written, flag_value, stack_fault, output ready);
endinterface

>>> rtl/c8ie_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/c8ie_exec.sv
// Instruction execute logic: computes next PC, index, register/flag writes, stack ops.
// Depends on c8ie_pkg; operands come from the register file and stack memories.
module c8ie_exec #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
    input  c8ie_pkg::t_item                    i_item,
    input  logic [c8ie_pkg::REG_W-1:0]         i_vx,
    input  logic [c8ie_pkg::REG_W-1:0]         i_vy,
    input  logic [c8ie_pkg::ADDR_W-1:0]        i_stk_top,
    input  logic [c8ie_pkg::ADDR_W-1:0]        i_pc,
    input  logic [c8ie_pkg::ADDR_W-1:0]        i_index,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]   i_level,
    output c8ie_pkg::t_result                  o_res,
    output c8ie_pkg::t_stk_ctl                 o_stk
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    logic [c8ie_pkg::REG_W-1:0]  nn;
    logic [c8ie_pkg::ADDR_W-1:0] nnn;
    logic [c8ie_pkg::ADDR_W-1:0] pc_fetch;
    logic [c8ie_pkg::REG_W:0]    sum;
    logic                        pressed;
    logic                        skip;
    logic                        wr;
    logic [c8ie_pkg::REG_W-1:0]  wval;

    assign nn       = {i_item.reg_y, i_item.nibble_n};
    assign nnn      = {i_item.reg_x, i_item.reg_y, i_item.nibble_n};
    assign pc_fetch = i_pc + c8ie_pkg::PC_STEP;
    assign sum      = {1'b0, i_vx} + {1'b0, i_vy};
    assign pressed  = i_item.key_states[i_vx[c8ie_pkg::NIB_W-1:0]];

    // opcode decode
    always_comb begin
        o_res              = '0;
        o_stk              = '0;
        o_res.next_pc      = pc_fetch;
        o_res.index_value  = i_index;
        o_stk.push_data    = pc_fetch;
        skip               = 1'b0;
        wr                 = 1'b0;
        wval               = '0;
        unique case (i_item.operation)
            c8ie_pkg::OP_RET: begin
                if (i_level == '0) begin
                    o_res.stack_fault = 1'b1;
                end else begin
                    o_stk.pop     = 1'b1;
                    o_res.next_pc = i_stk_top;
                end
            end
            c8ie_pkg::OP_JMP: o_res.next_pc = nnn;
            c8ie_pkg::OP_CALL: begin
                if (i_level >= LVL_W'(STACK_DEPTH)) begin
                    o_res.stack_fault = 1'b1;
                end else begin
                    o_stk.push    = 1'b1;
                    o_res.next_pc = nnn;
                end
            end
            c8ie_pkg::OP_SKEQI: skip = (i_vx == nn);
            c8ie_pkg::OP_SKNEI: skip = (i_vx != nn);
            c8ie_pkg::OP_SKEQR: skip = (i_vx == i_vy);
            c8ie_pkg::OP_SKNER: skip = (i_vx != i_vy);
            c8ie_pkg::OP_SETNN: begin
                wr   = 1'b1;
                wval = nn;
            end
            c8ie_pkg::OP_ADDNN: begin
                wr   = 1'b1;
                wval = i_vx + nn;
            end
            c8ie_pkg::OP_SETI: o_res.index_value = nnn;
            c8ie_pkg::OP_MOV: begin
                wr   = 1'b1;
                wval = i_vy;
            end
            c8ie_pkg::OP_OR: begin
                wr   = 1'b1;
                wval = i_vx | i_vy;
            end
            c8ie_pkg::OP_AND: begin
                wr   = 1'b1;
                wval = i_vx & i_vy;
            end
            c8ie_pkg::OP_XOR: begin
                wr   = 1'b1;
                wval = i_vx ^ i_vy;
            end
            c8ie_pkg::OP_ADDC: begin
                wr                 = 1'b1;
                wval               = sum[c8ie_pkg::REG_W-1:0];
                o_res.flag_written = 1'b1;
                o_res.flag_value   = sum[c8ie_pkg::REG_W];
            end
            c8ie_pkg::OP_SUBN: begin
                wr                 = 1'b1;
                wval               = i_vy - i_vx;
                o_res.flag_written = 1'b1;
                o_res.flag_value   = (i_vy >= i_vx);
            end
            c8ie_pkg::OP_SHR: begin
                wr                 = 1'b1;
                wval               = i_vy >> 1;
                o_res.flag_written = 1'b1;
                o_res.flag_value   = i_vy[0];
            end
            c8ie_pkg::OP_SHL: begin
                wr                 = 1'b1;
                wval               = i_vy << 1;
                o_res.flag_written = 1'b1;
                o_res.flag_value   = i_vy[c8ie_pkg::REG_W-1];
            end
            // i_vy carries V0 for this opcode
            c8ie_pkg::OP_JMPV0: o_res.next_pc = nnn + c8ie_pkg::ADDR_W'(i_vy);
            c8ie_pkg::OP_RAND: begin
                wr   = 1'b1;
                wval = i_item.random_byte & nn;
            end
            c8ie_pkg::OP_KEY: begin
                if (nn == c8ie_pkg::KEY_DOWN) begin
                    skip = pressed;
                end else if (nn == c8ie_pkg::KEY_UP) begin
                    skip = !pressed;
                end
            end
            default: ;
        endcase

        if (skip) begin
            o_res.next_pc = pc_fetch + c8ie_pkg::PC_STEP;
        end
        o_res.reg_written   = wr;
        o_res.written_reg   = wr ? i_item.reg_x : '0;
        o_res.written_value = wval;
    end

endmodule

>>> rtl/chip8_instruction_execute.sv
// CHIP-8 execute unit. Takes one decoded instruction item per clock while the result
// channel is not stalled and returns one result item per instruction: the PC after the
// fetch advance and the instruction, the index register, any VX or VF write and a stack
// fault flag. Each item passes the register file and stack memory read, then execute into
// the output register; sustained rate is one item per cycle while o_result.ready holds, set
// by the single read-modify-write pass through the register file memory, with forwarding of
// the previous instruction's write. No clearing pass after reset: per-entry valid bits make
// unwritten registers read as zero. start_address is readable and writable on the APB port;
// reset loads the PC with 0x200. V0..VE live in memory, VF in a flop. Stack depth is set by STACK_DEPTH.
// Depends on c8ie_pkg, c8ie_if, c8ie_ram, c8ie_exec and the defines header.
`include "chip8_instruction_execute_defines.svh"

module chip8_instruction_execute #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c8ie_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [c8ie_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [c8ie_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    c8ie_item_if.sink                         i_item,
    c8ie_result_if.source                     o_result
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int RI_W  = c8ie_pkg::NIB_W;
    localparam int RW    = c8ie_pkg::REG_W;
    localparam int AW    = c8ie_pkg::ADDR_W;

    // handshake and pipeline control
    logic                  in_acc;
    logic                  in_rdy;
    logic                  s1_adv;
    c8ie_pkg::t_item       in_item;

    // stage 1 (memory data valid) and output register
    logic                  r_s1_vld;
    c8ie_pkg::t_item       r_s1;
    logic [RI_W-1:0]       r_s1_ra;
    logic [RI_W-1:0]       r_s1_rb;
    logic [SP_W-1:0]       r_s1_sa;
    logic                  r_out_vld;
    c8ie_pkg::t_result     r_out;

    // architectural state in flops
    logic [AW-1:0]         r_pc;
    logic [AW-1:0]         r_index;
    logic [LVL_W-1:0]      r_level;
    logic [LVL_W-1:0]      n_level;
    logic [LVL_W-1:0]      exec_level;
    logic [RW-1:0]         r_vf;
    logic [c8ie_pkg::NUM_REGS-1:0] r_rf_vld;
    logic [AW-1:0]         r_start_addr;

    // forwarding records of the write made at the accept edge
    logic                  r_fwd_vld;
    logic [RI_W-1:0]       r_fwd_addr;
    logic [RW-1:0]         r_fwd_data;
    logic                  r_sfwd_vld;
    logic [SP_W-1:0]       r_sfwd_addr;
    logic [AW-1:0]         r_sfwd_data;

    // memory ports
    logic [RI_W-1:0]       rd_b_addr;
    logic [SP_W-1:0]       stk_raddr;
    logic [RW-1:0]         rf_a_data;
    logic [RW-1:0]         rf_b_data;
    logic [AW-1:0]         stk_rdata;
    logic                  rf_we;
    logic                  stk_we;
    logic [SP_W-1:0]       stk_waddr;

    // execute operands and outcome
    logic [RW-1:0]         vx;
    logic [RW-1:0]         vy;
    logic [AW-1:0]         stk_top;
    c8ie_pkg::t_result     res;
    c8ie_pkg::t_stk_ctl    stk;

    // config
    logic                  cfg_hit;

    // ---------------- handshake ----------------
    assign in_item.operation   = i_item.operation;
    assign in_item.reg_x       = i_item.reg_x;
    assign in_item.reg_y       = i_item.reg_y;
    assign in_item.nibble_n    = i_item.nibble_n;
    assign in_item.random_byte = i_item.random_byte;
    assign in_item.key_states  = i_item.key_states;

    assign s1_adv       = r_s1_vld && (!r_out_vld || o_result.ready);
    assign in_rdy       = !r_s1_vld || s1_adv;
    assign in_acc       = i_item.valid && in_rdy;
    assign i_item.ready = in_rdy;

    // ---------------- memory addressing ----------------
    // port B fetches V0 for jump-plus-V0
    assign rd_b_addr = (i_item.operation == c8ie_pkg::OP_JMPV0) ? '0 : i_item.reg_y;

    // stack level after the instruction now executing
    always_comb begin
        exec_level = r_level;
        if (stk.push) begin
            exec_level = r_level + LVL_W'(1);
        end else if (stk.pop) begin
            exec_level = r_level - LVL_W'(1);
        end
    end
    assign n_level   = s1_adv ? exec_level : r_level;
    assign stk_raddr = SP_W'(n_level - LVL_W'(1));

    assign rf_we     = s1_adv && res.reg_written && (r_s1.reg_x != c8ie_pkg::FLAG_REG);
    assign stk_we    = s1_adv && stk.push;
    assign stk_waddr = r_level[SP_W-1:0];

    // two copies of V0..VE give two read ports
    c8ie_ram #(.WIDTH(RW), .DEPTH(c8ie_pkg::NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s1.reg_x),
        .i_wdata (res.written_value),
        .i_re    (in_acc),
        .i_raddr (i_item.reg_x),
        .o_rdata (rf_a_data)
    );

    c8ie_ram #(.WIDTH(RW), .DEPTH(c8ie_pkg::NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s1.reg_x),
        .i_wdata (res.written_value),
        .i_re    (in_acc),
        .i_raddr (rd_b_addr),
        .o_rdata (rf_b_data)
    );

    c8ie_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk.push_data),
        .i_re    (in_acc),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // ---------------- operand select: VF flop, forward, valid bit ----------------
    always_comb begin
        if (r_s1_ra == c8ie_pkg::FLAG_REG) begin
            vx = r_vf;
        end else if (r_fwd_vld && (r_fwd_addr == r_s1_ra)) begin
            vx = r_fwd_data;
        end else if (r_rf_vld[r_s1_ra]) begin
            vx = rf_a_data;
        end else begin
            vx = '0;
        end

        if (r_s1_rb == c8ie_pkg::FLAG_REG) begin
            vy = r_vf;
        end else if (r_fwd_vld && (r_fwd_addr == r_s1_rb)) begin
            vy = r_fwd_data;
        end else if (r_rf_vld[r_s1_rb]) begin
            vy = rf_b_data;
        end else begin
            vy = '0;
        end

        if (r_sfwd_vld && (r_sfwd_addr == r_s1_sa)) begin
            stk_top = r_sfwd_data;
        end else begin
            stk_top = stk_rdata;
        end
    end

    c8ie_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
        .i_item    (r_s1),
        .i_vx      (vx),
        .i_vy      (vy),
        .i_stk_top (stk_top),
        .i_pc      (r_pc),
        .i_index   (r_index),
        .i_level   (r_level),
        .o_res     (res),
        .o_stk     (stk)
    );

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pc       <= c8ie_pkg::START_RESET;
            r_index    <= '0;
            r_level    <= '0;
            r_vf       <= '0;
            r_rf_vld   <= '0;
            r_fwd_vld  <= 1'b0;
            r_sfwd_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld   <= 1'b1;
                r_fwd_vld  <= rf_we;
                r_sfwd_vld <= stk_we;
            end else if (s1_adv) begin
                r_s1_vld   <= 1'b0;
            end

            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end

            // commit architectural state
            if (s1_adv) begin
                r_pc    <= res.next_pc;
                r_index <= res.index_value;
                r_level <= exec_level;
                if (res.flag_written) begin
                    r_vf <= RW'(res.flag_value);
                end else if (res.reg_written && (r_s1.reg_x == c8ie_pkg::FLAG_REG)) begin
                    r_vf <= res.written_value;
                end
            end
            if (rf_we) begin
                r_rf_vld[r_s1.reg_x] <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1        <= in_item;
            r_s1_ra     <= i_item.reg_x;
            r_s1_rb     <= rd_b_addr;
            r_s1_sa     <= stk_raddr;
            r_fwd_addr  <= r_s1.reg_x;
            r_fwd_data  <= res.written_value;
            r_sfwd_addr <= stk_waddr;
            r_sfwd_data <= stk.push_data;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    // ---------------- result channel ----------------
    assign o_result.valid         = r_out_vld;
    assign o_result.next_pc       = r_out.next_pc;
    assign o_result.index_value   = r_out.index_value;
    assign o_result.reg_written   = r_out.reg_written;
    assign o_result.written_reg   = r_out.written_reg;
    assign o_result.written_value = r_out.reg_written ? r_out.written_value : '0;
    assign o_result.flag_written  = r_out.flag_written;
    assign o_result.flag_value    = r_out.flag_value;
    assign o_result.stack_fault   = r_out.stack_fault;

    // ---------------- APB config ----------------
    assign cfg_hit = (paddr[c8ie_pkg::CFG_ADDR_W-1:2] == c8ie_pkg::CFG_IDX_START);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? c8ie_pkg::CFG_DATA_W'(r_start_addr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr <= c8ie_pkg::START_RESET;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_start_addr <= pwdata[AW-1:0];
        end
    end

    // ---------------- assertions ----------------
    `C8IE_ASSERT_NOW(a_level_bound, i_clk, i_rst_n, 1'b1, r_level <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
    `C8IE_ASSERT_NOW(a_accept_moves, i_clk, i_rst_n, in_acc && r_s1_vld, s1_adv, "item accepted over a held stage")
    `C8IE_ASSERT_NEXT(a_rf_valid, i_clk, i_rst_n, rf_we, r_rf_vld[$past(r_s1.reg_x)], "written register not marked valid")
    `C8IE_ASSERT_NEXT(a_push_level, i_clk, i_rst_n, s1_adv && stk.push, r_level == $past(r_level) + LVL_W'(1), "push did not raise level")
    `C8IE_ASSERT_NEXT(a_fault_level, i_clk, i_rst_n, s1_adv && res.stack_fault, $stable(r_level), "faulted stack op changed level")

endmodule

>>> sim/tb_top.sv
// Self-checking bench for chip8_instruction_execute: directed and random instructions on
// the item channel, prediction of PC, index and register writes, APB start_address checks.
// Depends on c8ie_pkg, the c8ie_if channel interfaces and the execute unit RTL.
import c8ie_pkg::*;

// Tracks the architectural state and holds the outcomes still owed by the block
class exec_scoreboard;
    localparam int STACK_LEVELS = STACK_DEPTH_DEF;

    bit [REG_W-1:0]  vregs [NUM_REGS];
    bit [ADDR_W-1:0] pc;
    bit [ADDR_W-1:0] index_reg;
    bit [ADDR_W-1:0] ret_addr [STACK_LEVELS];
    int              level;
    bit [ADDR_W-1:0] start_addr;
    t_result         expected_outcomes [$];
    int              errors;

    function new();
        foreach (vregs[i]) vregs[i] = '0;
        pc         = START_RESET;
        index_reg  = '0;
        level      = 0;
        start_addr = START_RESET;
        errors     = 0;
    endfunction

    function int pending();
        return expected_outcomes.size();
    endfunction

    function void set_vx(inout t_result res, input bit [NIB_W-1:0] x, input bit [REG_W-1:0] v);
        vregs[x]          = v;
        res.reg_written   = 1'b1;
        res.written_reg   = x;
        res.written_value = v;
    endfunction

    // Flag goes in after VX, so it wins when X is VF
    function void set_flag(inout t_result res, input bit f);
        vregs[FLAG_REG]  = {{(REG_W-1){1'b0}}, f};
        res.flag_written = 1'b1;
        res.flag_value   = f;
    endfunction

    // Runs one accepted instruction and queues the outcome it must produce
    function void execute_item(t_item it);
        t_result         res;
        bit [REG_W-1:0]  nn;
        bit [ADDR_W-1:0] nnn;
        bit [REG_W-1:0]  vx;
        bit [REG_W-1:0]  vy;
        bit [REG_W:0]    sum;
        bit              skip;
        bit              pressed;
        nn   = {it.reg_y, it.nibble_n};
        nnn  = {it.reg_x, nn};
        vx   = vregs[it.reg_x];
        vy   = vregs[it.reg_y];
        res  = '0;
        skip = 1'b0;
        // fetch advance comes first
        pc = pc + PC_STEP;
        case (it.operation)
            OP_RET: begin
                if (level == 0) begin
                    res.stack_fault = 1'b1;
                end else begin
                    level--;
                    pc = ret_addr[level];
                end
            end
            OP_JMP: pc = nnn;
            OP_CALL: begin
                if (level >= STACK_LEVELS) begin
                    res.stack_fault = 1'b1;
                end else begin
                    ret_addr[level] = pc;
                    level++;
                    pc = nnn;
                end
            end
            OP_SKEQI: skip = (vx == nn);
            OP_SKNEI: skip = (vx != nn);
            OP_SKEQR: skip = (vx == vy);
            OP_SKNER: skip = (vx != vy);
            OP_SETNN: set_vx(res, it.reg_x, nn);
            OP_ADDNN: set_vx(res, it.reg_x, vx + nn);
            OP_SETI:  index_reg = nnn;
            OP_MOV:   set_vx(res, it.reg_x, vy);
            OP_OR:    set_vx(res, it.reg_x, vx | vy);
            OP_AND:   set_vx(res, it.reg_x, vx & vy);
            OP_XOR:   set_vx(res, it.reg_x, vx ^ vy);
            OP_ADDC: begin
                sum = {1'b0, vx} + {1'b0, vy};
                set_vx(res, it.reg_x, sum[REG_W-1:0]);
                set_flag(res, sum[REG_W]);
            end
            OP_SUBN: begin
                set_vx(res, it.reg_x, vy - vx);
                set_flag(res, vy >= vx);
            end
            OP_SHR: begin
                set_vx(res, it.reg_x, vy >> 1);
                set_flag(res, vy[0]);
            end
            OP_SHL: begin
                set_vx(res, it.reg_x, vy << 1);
                set_flag(res, vy[REG_W-1]);
            end
            OP_JMPV0: pc = nnn + {{(ADDR_W-REG_W){1'b0}}, vregs[0]};
            OP_RAND:  set_vx(res, it.reg_x, it.random_byte & nn);
            OP_KEY: begin
                // only the low nibble of VX picks the key
                pressed = it.key_states[vx[NIB_W-1:0]];
                if (nn == KEY_DOWN) begin
                    skip = pressed;
                end else if (nn == KEY_UP) begin
                    skip = !pressed;
                end
            end
            default: ;
        endcase
        if (skip) pc = pc + PC_STEP;
        res.next_pc     = pc;
        res.index_value = index_reg;
        expected_outcomes.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_outcome(t_result got);
        t_result want;
        if (expected_outcomes.size() == 0) begin
            $error("result item with no instruction outstanding (next_pc 0x%0h)", got.next_pc);
            errors++;
            return;
        end
        want = expected_outcomes.pop_front();
        compare_field("next_pc", 16'(want.next_pc), 16'(got.next_pc));
        compare_field("index_value", 16'(want.index_value), 16'(got.index_value));
        compare_field("reg_written", 16'(want.reg_written), 16'(got.reg_written));
        compare_field("written_reg", 16'(want.written_reg), 16'(got.written_reg));
        compare_field("written_value", 16'(want.written_value), 16'(got.written_value));
        compare_field("flag_written", 16'(want.flag_written), 16'(got.flag_written));
        compare_field("flag_value", 16'(want.flag_value), 16'(got.flag_value));
        compare_field("stack_fault", 16'(want.stack_fault), 16'(got.stack_fault));
    endfunction
endclass

module tb_top;
    localparam int STACK_LEVELS  = STACK_DEPTH_DEF;
    localparam int RESET_CYCLES  = 11;
    localparam int TOTAL_ITEMS   = 500;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [OP_W-1:0]       OP_LAST_CODE   = '1;
    localparam logic [CFG_ADDR_W-1:0] START_REG_ADDR = {CFG_IDX_START, 2'b00};

    typedef enum {MIX_ANY, MIX_CALLS, MIX_RETS} t_mix;
    typedef enum {SINK_OPEN, SINK_COIN, SINK_RHYTHM, SINK_TIGHT} t_sink_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    c8ie_item_if   item_ch ();
    c8ie_result_if result_ch ();

    exec_scoreboard sb;
    int             burst_left;
    int             items_sent;
    bit             hold_off_req;

    chip8_instruction_execute #(.STACK_DEPTH(STACK_LEVELS)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_item make_item(logic [OP_W-1:0] op, logic [NIB_W-1:0] x,
                                        logic [NIB_W-1:0] y, logic [NIB_W-1:0] n,
                                        logic [REG_W-1:0] rnd, logic [KEY_W-1:0] keys);
        t_item it;
        it.operation   = op;
        it.reg_x       = x;
        it.reg_y       = y;
        it.nibble_n    = n;
        it.random_byte = rnd;
        it.key_states  = keys;
        return it;
    endfunction

    // Random instruction; compares and key codes are steered so both outcomes show up
    function automatic t_item random_item(t_mix mix);
        t_item          it;
        int             pick;
        logic [REG_W-1:0] nn;
        it.reg_x       = NIB_W'($urandom_range(0, 15));
        it.reg_y       = NIB_W'($urandom_range(0, 15));
        it.nibble_n    = NIB_W'($urandom_range(0, 15));
        it.random_byte = REG_W'($urandom_range(0, 255));
        it.key_states  = KEY_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (mix == MIX_CALLS && pick < 45) begin
            it.operation = OP_CALL;
        end else if (mix == MIX_RETS && pick < 45) begin
            it.operation = OP_RET;
        end else if (pick % 10 == 0) begin
            it.operation = OP_W'($urandom_range(int'(OP_KEY) + 1, int'(OP_LAST_CODE)));
        end else begin
            it.operation = OP_W'($urandom_range(0, int'(OP_KEY)));
        end
        case (it.operation)
            OP_SKEQI, OP_SKNEI: begin
                if ($urandom_range(0, 1) == 1) {it.reg_y, it.nibble_n} = sb.vregs[it.reg_x];
            end
            OP_SKEQR, OP_SKNER: begin
                if ($urandom_range(0, 2) == 0) it.reg_y = it.reg_x;
            end
            OP_KEY: begin
                case ($urandom_range(0, 4))
                    0, 1:    nn = KEY_DOWN;
                    2, 3:    nn = KEY_UP;
                    default: nn = REG_W'($urandom_range(0, 255));
                endcase
                {it.reg_y, it.nibble_n} = nn;
            end
            default: ;
        endcase
        return it;
    endfunction

    // Sender runs in bursts; a gap between bursts drops valid
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_item(t_item it);
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= it.operation;
        item_ch.reg_x       <= it.reg_x;
        item_ch.reg_y       <= it.reg_y;
        item_ch.nibble_n    <= it.nibble_n;
        item_ch.random_byte <= it.random_byte;
        item_ch.key_states  <= it.key_states;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sb.execute_item(it);
        items_sent++;
        pace();
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // APB: setup cycle, access cycle, then back to idle
    task automatic cfg_write(logic [ADDR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_REG_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.start_addr = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= START_REG_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.compare_field("start_address", 16'(sb.start_addr), prdata[15:0]);
        if (prdata[CFG_DATA_W-1:16] !== '0) begin
            $error("start_address: expected upper bits 0, got 0x%0h", prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [ADDR_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(value);
        cfg_check();
    endtask

    // Result sink: changing stall patterns, plus one long hold-off on request
    initial begin : result_sink
        t_sink_mode mode;
        int         phase_left;
        result_ch.ready <= 1'b0;
        mode       = SINK_OPEN;
        phase_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = t_sink_mode'($urandom_range(0, 3));
                    phase_left = $urandom_range(8, 40);
                end
                phase_left--;
                case (mode)
                    SINK_OPEN:   result_ch.ready <= 1'b1;
                    SINK_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_RHYTHM: result_ch.ready <= (phase_left % 3 != 0);
                    default:     result_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            sb.check_outcome({result_ch.next_pc, result_ch.index_value, result_ch.reg_written,
                              result_ch.written_reg, result_ch.written_value,
                              result_ch.flag_written, result_ch.flag_value,
                              result_ch.stack_fault});
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int   seg;
        int   len;
        t_mix mix;
        sb           = new();
        burst_left   = 0;
        items_sent   = 0;
        hold_off_req = 1'b0;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.operation   <= '0;
        item_ch.reg_x       <= '0;
        item_ch.reg_y       <= '0;
        item_ch.nibble_n    <= '0;
        item_ch.random_byte <= '0;
        item_ch.key_states  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start_address: reset value, then the top extreme
        cfg_check();
        cfg_write('1);
        cfg_check();

        // Directed: every operation, field extremes, the corner cases
        send_item(make_item(OP_RET,   4'h0, 4'h0, 4'h0, 8'h00, 16'h0000)); // pop from empty stack
        send_item(make_item(OP_SETNN, 4'h0, 4'hF, 4'hF, 8'hFF, 16'hFFFF));
        send_item(make_item(OP_SETNN, 4'h1, 4'h0, 4'h1, 8'h00, 16'h0000));
        send_item(make_item(OP_ADDNN, 4'h0, 4'h0, 4'h1, 8'h00, 16'h0000)); // wraps, no flag
        send_item(make_item(OP_SETNN, 4'h0, 4'hF, 4'hF, 8'h00, 16'h0000));
        send_item(make_item(OP_ADDC,  4'h0, 4'h1, 4'h0, 8'h00, 16'h0000)); // carry out
        send_item(make_item(OP_ADDC,  4'hF, 4'h1, 4'h0, 8'h00, 16'h0000)); // VF as target
        send_item(make_item(OP_SUBN,  4'h1, 4'h0, 4'h0, 8'h00, 16'h0000)); // borrow
        send_item(make_item(OP_SUBN,  4'h3, 4'h3, 4'h0, 8'h00, 16'h0000)); // equal: no borrow
        send_item(make_item(OP_SHR,   4'h4, 4'h1, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_SHL,   4'hF, 4'h1, 4'h0, 8'h00, 16'h0000)); // VF as target
        send_item(make_item(OP_MOV,   4'h6, 4'h4, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_OR,    4'h6, 4'h1, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_AND,   4'h7, 4'h4, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_XOR,   4'h6, 4'h1, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_SETI,  4'hF, 4'hF, 4'hF, 8'h00, 16'h0000));
        send_item(make_item(OP_SKEQI, 4'h2, 4'h0, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_SKNEI, 4'h2, 4'h0, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_SKEQR, 4'h5, 4'h2, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_SKNER, 4'h1, 4'h4, 4'h0, 8'h00, 16'h0000));
        // VX=0x7F: only its low nibble selects the key
        send_item(make_item(OP_KEY,   4'h4, 4'h9, 4'hE, 8'h00, 16'h8000));
        send_item(make_item(OP_KEY,   4'h4, 4'hA, 4'h1, 8'h00, 16'h8000));
        send_item(make_item(OP_KEY,   4'h4, 4'h0, 4'h0, 8'h00, 16'hFFFF)); // unknown key code
        send_item(make_item(OP_RAND,  4'h5, 4'hF, 4'hF, 8'hA5, 16'h0000));
        send_item(make_item(OP_JMP,   4'hF, 4'hF, 4'hF, 8'h00, 16'h0000)); // PC wraps next
        send_item(make_item(OP_CALL,  4'h0, 4'h0, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_RET,   4'h0, 4'h0, 4'h0, 8'h00, 16'h0000));
        send_item(make_item(OP_JMPV0, 4'hF, 4'hF, 4'hF, 8'h00, 16'h0000));
        send_item(make_item(OP_LAST_CODE, 4'h0, 4'h0, 4'h0, 8'h00, 16'h0000)); // unused code

        reconfigure('0);

        // Fill the stack past its depth, then unwind past empty
        repeat (STACK_LEVELS + 1) begin
            send_item(make_item(OP_CALL, NIB_W'($urandom_range(0, 15)),
                                NIB_W'($urandom_range(0, 15)), NIB_W'($urandom_range(0, 15)),
                                REG_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 65535))));
        end
        repeat (STACK_LEVELS + 1) begin
            send_item(make_item(OP_RET, NIB_W'($urandom_range(0, 15)),
                                NIB_W'($urandom_range(0, 15)), NIB_W'($urandom_range(0, 15)),
                                REG_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 65535))));
        end

        // Random segments with call/return bias, back-pressure and config changes between
        seg = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 1) == 1) begin
                mix = MIX_ANY;
            end else begin
                mix = ($urandom_range(0, 1) == 1) ? MIX_CALLS : MIX_RETS;
            end
            len = $urandom_range(20, 60);
            if (seg == 2) hold_off_req = 1'b1;
            if (seg == 4) wait_drained();
            if (seg == 3 || seg == 6) reconfigure(ADDR_W'($urandom_range(1, 4094)));
            repeat (len) send_item(random_item(mix));
            seg++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/c8ie_pkg.sv
rtl/c8ie_if.sv
rtl/c8ie_ram.sv
rtl/c8ie_exec.sv
rtl/chip8_instruction_execute.sv
sim/tb_top.sv
